[sv/bm25s_pkg.sv]
// ----------------------------------------------------------------------------
// BM25 scorer package
// Shared widths, register indexes, reset values and interface structs of the
// BM25 document scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package bm25s_pkg;

    // Register file
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_K1  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K3  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG = 8'd3;

    localparam logic [15:0] K1_RESET  = 16'd6144;
    localparam logic [15:0] B_RESET   = 16'd24576;
    localparam logic [15:0] K3_RESET  = 16'd1000;
    localparam logic [23:0] AVG_RESET = 24'd256;

    // Fixed-point constants
    localparam logic [15:0] B_ONE  = 16'd32768;
    localparam logic [16:0] K1_ONE = 17'd4096;

    // Score accumulator
    localparam int SCORE_W = 40;
    localparam int ADD_W   = 37;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // Shared divider
    localparam int DIV_DW = 46;
    localparam int DIV_LW = 40;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] R_STEPS   = 6'd40;
    localparam logic [STEP_W-1:0] TFW_STEPS = 6'd21;
    localparam logic [STEP_W-1:0] QW_STEPS  = 6'd24;

    typedef struct packed {
        logic [15:0] k1;
        logic [15:0] b;
        logic [15:0] k3;
        logic [23:0] avg;
    } t_cfg;

    typedef struct packed {
        logic [15:0] doc_length;
        logic [15:0] term_freq;
        logic [7:0]  query_freq;
        logic [23:0] term_weight;
        logic        last;
    } t_item;

    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic               ovf;
    } t_res;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] rem_init;
        logic [DIV_LW-1:0] low;
        logic [DIV_DW-1:0] den;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_LW-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

[sv/bm25_document_scorer.sv]
// ----------------------------------------------------------------------------
// BM25 document scorer
// Accumulates Okapi BM25 term contributions of one document and emits its
// saturating Q24.16 score on the term marked last.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction carries one matched query term of a document. The
// input channel is taken when i_in_valid is high and o_in_stall is low. A
// term with nonzero term and query frequency goes from the idle state that
// takes the transaction through the multiplier and sequencer states and three
// uses of the shared one-bit-per-cycle divider to one accumulate state before
// the next transaction is accepted; a term with a zero frequency goes from
// the idle state straight to the accumulate state.
// On a term marked last the score is placed in the output register in the
// cycle the term finishes; o_out_valid then holds with a stable payload
// until a cycle with i_out_stall low. A new term is accepted while a result
// waits; a further last term waits in its final step until the register
// frees. The configuration port is always ready; the user must write it only
// while the block is idle, which the block itself does not enforce. Reset
// restores the default k1, b, k3 and average length, clears the running
// score and the saturation flag, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bm25_document_scorer import bm25s_pkg::*; #(
    parameter int DOC_ID_WIDTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [DOC_ID_WIDTH-1:0] i_doc_id,
    input  wire logic [15:0]             i_doc_length,
    input  wire logic [15:0]             i_term_freq,
    input  wire logic [7:0]              i_query_freq,
    input  wire logic [23:0]             i_term_weight,
    input  wire logic                    i_last,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [DOC_ID_WIDTH-1:0]      o_doc_id_out,
    output logic [SCORE_W-1:0]           o_score,
    output logic                         o_overflowed
);

    t_cfg                    r_cfg;
    logic                    r_out_valid;
    logic [DOC_ID_WIDTH-1:0] r_out_id;
    logic [SCORE_W-1:0]      r_out_score;
    logic                    r_out_ovf;

    t_item                   item;
    t_res                    res;
    logic [DOC_ID_WIDTH-1:0] res_id;
    logic                    idle;
    logic                    accept;
    logic                    res_ready;

    assign item.doc_length  = i_doc_length;
    assign item.term_freq   = i_term_freq;
    assign item.query_freq  = i_query_freq;
    assign item.term_weight = i_term_weight;
    assign item.last        = i_last;

    assign o_in_stall  = !idle;
    assign accept      = i_in_valid && !o_in_stall;
    assign res_ready   = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    bm25s_core #(
        .DOC_ID_WIDTH (DOC_ID_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (accept),
        .i_doc_id    (i_doc_id),
        .i_item      (item),
        .i_res_ready (res_ready),
        .o_idle      (idle),
        .o_res       (res),
        .o_doc_id    (res_id)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k1  <= K1_RESET;
            r_cfg.b   <= B_RESET;
            r_cfg.k3  <= K3_RESET;
            r_cfg.avg <= AVG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_K1:  r_cfg.k1  <= i_cfg_data[15:0];
                CFG_B:   r_cfg.b   <= i_cfg_data[15:0];
                CFG_K3:  r_cfg.k3  <= i_cfg_data[15:0];
                CFG_AVG: r_cfg.avg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_id    <= res_id;
            r_out_score <= res.score;
            r_out_ovf   <= res.ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_doc_id_out = r_out_id;
    assign o_score      = r_out_score;
    assign o_overflowed = r_out_ovf;

endmodule

`default_nettype wire

[sv/bm25s_div.sv]
// ----------------------------------------------------------------------------
// BM25 scorer divider
// Restoring divider, one quotient bit per cycle, with a preloaded partial
// remainder so that a narrow quotient takes only as many steps as its width.
// ----------------------------------------------------------------------------
`default_nettype none

module bm25s_div import bm25s_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_LW-1:0] r_sh;

    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   diff;
    logic              fits;

    // The preloaded remainder is below the divisor, so every step keeps it so.
    assign rem_sh = {r_rem, r_sh[DIV_LW-1]};
    assign fits   = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_den <= i_req.den;
            r_sh  <= i_req.low;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            r_sh  <= {r_sh[DIV_LW-2:0], fits};
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == STEP_W'(1));
    assign o_rsp.quo  = r_sh;

endmodule

`default_nettype wire

[sv/bm25s_core.sv]
// ----------------------------------------------------------------------------
// BM25 scorer core
// Sequencer around one shared multiplier and the shared divider, computing one
// term's BM25 contribution and adding it to the saturating document score.
// ----------------------------------------------------------------------------
`default_nettype none

module bm25s_core import bm25s_pkg::*; #(
    parameter int DOC_ID_WIDTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_start,
    input  wire logic [DOC_ID_WIDTH-1:0] i_doc_id,
    input  wire t_item                   i_item,
    input  wire logic                    i_res_ready,
    output logic                         o_idle,
    output t_res                         o_res,
    output logic [DOC_ID_WIDTH-1:0]      o_doc_id
);

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000_0000_0000_0001,
        S_MUL_P  = 16'b0000_0000_0000_0010,
        S_MUL_Q  = 16'b0000_0000_0000_0100,
        S_DIV_R  = 16'b0000_0000_0000_1000,
        S_MUL_BL = 16'b0000_0000_0001_0000,
        S_MUL_BH = 16'b0000_0000_0010_0000,
        S_NORM   = 16'b0000_0000_0100_0000,
        S_MUL_KL = 16'b0000_0000_1000_0000,
        S_MUL_KH = 16'b0000_0001_0000_0000,
        S_DEN    = 16'b0000_0010_0000_0000,
        S_DIV_T  = 16'b0000_0100_0000_0000,
        S_QGO    = 16'b0000_1000_0000_0000,
        S_DIV_Q  = 16'b0001_0000_0000_0000,
        S_MUL_T  = 16'b0010_0000_0000_0000,
        S_MUL_A  = 16'b0100_0000_0000_0000,
        S_ACCUM  = 16'b1000_0000_0000_0000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;

    t_item                   r_item;
    logic [DOC_ID_WIDTH-1:0] r_id;
    logic                    r_skip;
    logic [63:0]             r_prod;
    logic [32:0]             r_p;
    logic [24:0]             r_q;
    logic [47:0]             r_acc;
    logic [40:0]             r_norm;
    logic [20:0]             r_tfw;
    logic [SCORE_W-1:0]      r_sum;
    logic                    r_sat;

    t_div_req                div_req;
    t_div_rsp                div_rsp;

    logic [15:0]             b_eff;
    logic [23:0]             avg_eff;
    logic [16:0]             k1p;
    logic [16:0]             k3p;
    logic [16:0]             qden;
    logic [55:0]             norm_sum;
    logic [56:0]             kn;
    logic [DIV_DW-1:0]       den;
    logic [ADD_W-1:0]        add;
    logic [SCORE_W:0]        sum_ext;
    logic [SCORE_W-1:0]      sum_new;
    logic                    sat_new;
    logic                    zero_term;
    logic                    acc_go;
    logic                    mul_en;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;

    bm25s_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign b_eff   = (i_cfg.b > B_ONE) ? B_ONE : i_cfg.b;
    assign avg_eff = (i_cfg.avg == '0) ? 24'd1 : i_cfg.avg;
    assign k1p     = {1'b0, i_cfg.k1} + K1_ONE;
    assign k3p     = {1'b0, i_cfg.k3} + 17'd1;
    assign qden    = 17'(r_item.query_freq) + {1'b0, i_cfg.k3};

    assign zero_term = (i_item.term_freq == '0) || (i_item.query_freq == '0);

    // norm = ((1 - b) + b * dl / avgdl) in Q.16, built from two partial products.
    assign norm_sum = 56'({B_ONE - b_eff, 16'b0}) + 56'(r_acc) + {r_prod[23:0], 32'b0};
    assign kn       = 57'(r_acc) + {r_prod[24:0], 32'b0};
    assign den      = DIV_DW'({r_item.term_freq, 16'b0}) + DIV_DW'(kn[56:12]);

    assign add     = r_skip ? '0 : r_prod[52:16];
    assign sum_ext = {1'b0, r_sum} + (SCORE_W+1)'(add);
    assign sum_new = sum_ext[SCORE_W] ? SCORE_MAX : sum_ext[SCORE_W-1:0];
    assign sat_new = r_sat | sum_ext[SCORE_W];
    assign acc_go  = (r_state == S_ACCUM) && (!r_item.last || i_res_ready);

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_MUL_P: begin
                mul_a = 32'(r_item.term_freq);
                mul_b = 32'(k1p);
            end
            S_MUL_Q: begin
                mul_a = 32'(r_item.query_freq);
                mul_b = 32'(k3p);
            end
            S_MUL_BL: begin
                mul_a = 32'(b_eff);
                mul_b = div_rsp.quo[31:0];
            end
            S_MUL_BH: begin
                mul_a = 32'(b_eff);
                mul_b = 32'(div_rsp.quo[39:32]);
            end
            S_MUL_KL: begin
                mul_a = 32'(i_cfg.k1);
                mul_b = r_norm[31:0];
            end
            S_MUL_KH: begin
                mul_a = 32'(i_cfg.k1);
                mul_b = 32'(r_norm[40:32]);
            end
            S_MUL_T: begin
                mul_a = 32'(r_item.term_weight);
                mul_b = 32'(r_tfw);
            end
            S_MUL_A: begin
                mul_a = 32'(r_prod[44:16]);
                mul_b = 32'(div_rsp.quo[23:0]);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.rem_init = '0;
        div_req.low      = {r_item.doc_length, 24'b0};
        div_req.den      = DIV_DW'(avg_eff);
        div_req.steps    = R_STEPS;
        unique case (r_state)
            S_MUL_Q: begin
                div_req.start = 1'b1;
            end
            S_DEN: begin
                div_req.start    = 1'b1;
                div_req.rem_init = DIV_DW'(r_p[32:1]);
                div_req.low      = {r_p[0], 39'b0};
                div_req.den      = den;
                div_req.steps    = TFW_STEPS;
            end
            S_QGO: begin
                div_req.start    = 1'b1;
                div_req.rem_init = DIV_DW'(r_q[24:8]);
                div_req.low      = {r_q[7:0], 32'b0};
                div_req.den      = DIV_DW'(qden);
                div_req.steps    = QW_STEPS;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = zero_term ? S_ACCUM : S_MUL_P;
            S_MUL_P:  n_state = S_MUL_Q;
            S_MUL_Q:  n_state = S_DIV_R;
            S_DIV_R:  if (div_rsp.done) n_state = S_MUL_BL;
            S_MUL_BL: n_state = S_MUL_BH;
            S_MUL_BH: n_state = S_NORM;
            S_NORM:   n_state = S_MUL_KL;
            S_MUL_KL: n_state = S_MUL_KH;
            S_MUL_KH: n_state = S_DEN;
            S_DEN:    n_state = S_DIV_T;
            S_DIV_T:  if (div_rsp.done) n_state = S_QGO;
            S_QGO:    n_state = S_DIV_Q;
            S_DIV_Q:  if (div_rsp.done) n_state = S_MUL_T;
            S_MUL_T:  n_state = S_MUL_A;
            S_MUL_A:  n_state = S_ACCUM;
            S_ACCUM:  if (acc_go) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_sat   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc_go) begin
                if (r_item.last) begin
                    r_sum <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_sum <= sum_new;
                    r_sat <= sat_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
        if ((r_state == S_IDLE) && i_start) begin
            r_item <= i_item;
            r_id   <= i_doc_id;
            r_skip <= zero_term;
        end
        if (r_state == S_MUL_Q) begin
            r_p <= r_prod[32:0];
        end
        // The multiplier is idle during the first division, so the product holds.
        if (r_state == S_DIV_R) begin
            r_q <= r_prod[24:0];
        end
        if ((r_state == S_MUL_BH) || (r_state == S_MUL_KH)) begin
            r_acc <= r_prod[47:0];
        end
        if (r_state == S_NORM) begin
            r_norm <= norm_sum[55:15];
        end
        if (r_state == S_QGO) begin
            r_tfw <= div_rsp.quo[20:0];
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_ACCUM) && r_item.last && i_res_ready;
    assign o_res.score = sum_new;
    assign o_res.ovf   = sat_new;
    assign o_doc_id    = r_id;

endmodule

`default_nettype wire

[sv/bm25s_checker.sv]
// ----------------------------------------------------------------------------
// BM25 scorer checker
// Port-level assertions on the BM25 document scorer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bm25s_checker import bm25s_pkg::*; #(
    parameter int DOC_ID_WIDTH = 32
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_stall,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire logic [DOC_ID_WIDTH-1:0] o_doc_id_out,
    input wire logic [SCORE_W-1:0]      o_score,
    input wire logic                    o_overflowed
);

    // Reset empties the output register and leaves the block ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle and empty after reset");

    // An accepted term keeps the sequencer busy, so the input stalls in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transaction");

    // A saturated score is always reported at its ceiling.
    a_sat_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflowed |-> o_score == SCORE_MAX)
        else $error("overflow flagged with a score below the ceiling");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_score)
            && $stable(o_overflowed) && $stable(o_doc_id_out))
        else $error("result changed while stalled");

endmodule

bind bm25_document_scorer bm25s_checker #(
    .DOC_ID_WIDTH (DOC_ID_WIDTH)
) u_bm25s_checker (.*);

`default_nettype wire

[bench/bm25_document_scorer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BM25 document scorer regression
// Feeds scripted and random query terms through the scorer, predicts every
// document score in fixed point, and checks each result transaction against
// the oldest prediction. Phases step through several register settings,
// including both extremes, under varying backpressure.
// ----------------------------------------------------------------------------

module bm25_document_scorer_test;
    import bm25s_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int HOLD_CYCLES    = 1500;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_TERMS    = 185;
    localparam int NUM_SCRIPTED   = 19;

    typedef struct packed {
        logic [31:0] doc_id;
        logic [15:0] doc_length;
        logic [15:0] term_freq;
        logic [7:0]  query_freq;
        logic [23:0] term_weight;
        logic        last;
    } t_term;

    typedef struct packed {
        logic [31:0]        doc_id;
        logic [SCORE_W-1:0] score;
        logic               overflowed;
    } t_doc_score;

    // One scripted term; when has_score is set the score is known by hand.
    typedef struct packed {
        logic [31:0]        doc_id;
        logic [15:0]        doc_length;
        logic [15:0]        term_freq;
        logic [7:0]         query_freq;
        logic [23:0]        term_weight;
        logic               last;
        logic               has_score;
        logic [SCORE_W-1:0] score;
        logic               overflowed;
    } t_scripted_term;

    // Under the reset settings a term with dl = 1, tf = 1 and qf = 1 adds
    // exactly its weight, which makes the hand-typed scores easy to read.
    localparam t_scripted_term SCRIPT [NUM_SCRIPTED] = '{
        '{32'h0000_0000, 16'd1,     16'd0,     8'd1,   24'h01_0000, 1'b1,
          1'b1, 40'd0, 1'b0},
        '{32'hFFFF_FFFF, 16'd1,     16'd1,     8'd0,   24'h01_0000, 1'b1,
          1'b1, 40'd0, 1'b0},
        '{32'h0000_0001, 16'd1,     16'd1,     8'd1,   24'h00_0000, 1'b1,
          1'b1, 40'd0, 1'b0},
        '{32'h1234_5678, 16'd1,     16'd1,     8'd1,   24'h01_0000, 1'b1,
          1'b1, 40'h00_0001_0000, 1'b0},
        '{32'hA5A5_A5A5, 16'd1,     16'd1,     8'd1,   24'hFF_FFFF, 1'b1,
          1'b1, 40'h00_00FF_FFFF, 1'b0},
        '{32'h0000_0010, 16'd1,     16'd1,     8'd1,   24'd100,     1'b0,
          1'b0, 40'd0, 1'b0},
        '{32'h0000_0011, 16'd1,     16'd1,     8'd1,   24'd200,     1'b1,
          1'b1, 40'd300, 1'b0},
        '{32'h5A5A_5A5A, 16'd0,     16'd1,     8'd1,   24'h01_0000, 1'b1,
          1'b0, 40'd0, 1'b0},
        '{32'hDEAD_BEEF, 16'hFFFF,  16'hFFFF,  8'hFF,  24'hFF_FFFF, 1'b1,
          1'b0, 40'd0, 1'b0},
        '{32'h0000_0020, 16'hFFFF,  16'd1,     8'hFF,  24'h01_2345, 1'b0,
          1'b0, 40'd0, 1'b0},
        '{32'h0000_0021, 16'd0,     16'hFFFF,  8'd1,   24'd777,     1'b0,
          1'b0, 40'd0, 1'b0},
        '{32'h0000_0022, 16'd300,   16'd7,     8'd3,   24'h02_0000, 1'b1,
          1'b0, 40'd0, 1'b0},
        '{32'h0000_0030, 16'd1,     16'd0,     8'd1,   24'hFF_FFFF, 1'b0,
          1'b0, 40'd0, 1'b0},
        '{32'h0000_0030, 16'd1,     16'd1,     8'd1,   24'd5,       1'b1,
          1'b1, 40'd5, 1'b0},
        '{32'h0000_0031, 16'd1,     16'd1,     8'd0,   24'hFF_FFFF, 1'b0,
          1'b0, 40'd0, 1'b0},
        '{32'h0000_0031, 16'd1,     16'd1,     8'd1,   24'd7,       1'b1,
          1'b1, 40'd7, 1'b0},
        '{32'h0000_0000, 16'd2,     16'd3,     8'd2,   24'h00_8000, 1'b1,
          1'b0, 40'd0, 1'b0},
        '{32'h8000_0000, 16'd40,    16'd12,    8'd9,   24'h03_C000, 1'b0,
          1'b0, 40'd0, 1'b0},
        '{32'h8000_0001, 16'd55,    16'd4,     8'd1,   24'h01_8000, 1'b1,
          1'b0, 40'd0, 1'b0}
    };

    logic                  i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic [31:0]           i_doc_id      = '0;
    logic [15:0]           i_doc_length  = '0;
    logic [15:0]           i_term_freq   = '0;
    logic [7:0]            i_query_freq  = '0;
    logic [23:0]           i_term_weight = '0;
    logic                  i_last        = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [31:0]           o_doc_id_out;
    logic [SCORE_W-1:0]    o_score;
    logic                  o_overflowed;

    bm25_document_scorer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_doc_id      (i_doc_id),
        .i_doc_length  (i_doc_length),
        .i_term_freq   (i_term_freq),
        .i_query_freq  (i_query_freq),
        .i_term_weight (i_term_weight),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_doc_id_out  (o_doc_id_out),
        .o_score       (o_score),
        .o_overflowed  (o_overflowed)
    );

    // Scorer settings and running sum as the testbench believes them to be.
    logic [15:0] k1_setting;
    logic [15:0] b_setting;
    logic [15:0] k3_setting;
    logic [23:0] avg_len_setting;
    logic [63:0] running_score;
    logic        running_saturated;

    t_doc_score  pending_scores[$];
    int          mismatches    = 0;
    int          terms_sent    = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requests = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Contribution of one term to the document score, Q.16.
    function automatic logic [63:0] term_score(input t_term t);
        logic [63:0] avg;
        logic [63:0] b;
        logic [63:0] ratio;
        logic [63:0] norm;
        logic [63:0] den;
        logic [63:0] tf_weight;
        logic [63:0] qf_weight;
        logic [63:0] weighted;
        avg = (avg_len_setting == '0) ? 64'd1 : 64'(avg_len_setting);
        b = (b_setting > B_ONE) ? 64'(B_ONE) : 64'(b_setting);
        if (t.term_freq == '0 || t.query_freq == '0)
            return 64'd0;
        ratio = (64'(t.doc_length) << 24) / avg;
        norm = (((64'd32768 - b) << 16) + b * ratio) >> 15;
        den = (64'(t.term_freq) << 16) + ((64'(k1_setting) * norm) >> 12);
        tf_weight = ((64'(t.term_freq) * (64'(k1_setting) + 64'd4096)) << 20) / den;
        qf_weight = ((64'(t.query_freq) * (64'(k3_setting) + 64'd1)) << 16)
                    / (64'(t.query_freq) + 64'(k3_setting));
        weighted = (64'(t.term_weight) * tf_weight) >> 16;
        return (weighted * qf_weight) >> 16;
    endfunction

    // Offers one term, waits for its transaction, then updates the running
    // score. A hand-typed score, when given, replaces the predicted one.
    task automatic send_term(input t_term t, input bit has_score,
                             input logic [SCORE_W-1:0] score, input logic ovf);
        logic [63:0] add;
        t_doc_score  expected;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_doc_id      <= t.doc_id;
        i_doc_length  <= t.doc_length;
        i_term_freq   <= t.term_freq;
        i_query_freq  <= t.query_freq;
        i_term_weight <= t.term_weight;
        i_last        <= t.last;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        terms_sent++;
        add = term_score(t);
        if (add > 64'(SCORE_MAX) - running_score) begin
            running_score = 64'(SCORE_MAX);
            running_saturated = 1'b1;
        end else begin
            running_score += add;
        end
        if (t.last) begin
            if (has_score)
                expected = '{t.doc_id, score, ovf};
            else
                expected = '{t.doc_id, running_score[SCORE_W-1:0], running_saturated};
            pending_scores.insert(pending_scores.size(), expected);
            running_score = '0;
            running_saturated = 1'b0;
        end
    endtask

    // Waits until every predicted score has come out and the scorer has had
    // time to finish a term that produces no result.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (index)
            CFG_K1:  k1_setting = data[15:0];
            CFG_B:   b_setting = data[15:0];
            CFG_K3:  k3_setting = data[15:0];
            CFG_AVG: avg_len_setting = data;
            default: ;
        endcase
    endtask

    // Reprograms all four registers; a stray write to an unused index is
    // mixed in and must leave the settings alone.
    task automatic program_scorer(input logic [CFG_DATA_W-1:0] k1,
                                  input logic [CFG_DATA_W-1:0] b,
                                  input logic [CFG_DATA_W-1:0] k3,
                                  input logic [CFG_DATA_W-1:0] avg);
        settle();
        write_register(CFG_K1, k1);
        if ($urandom_range(1) == 0)
            write_register(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
        write_register(CFG_B, b);
        write_register(CFG_K3, k3);
        write_register(CFG_AVG, avg);
        write_register({CFG_IDX_W{1'b1}}, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one random document. Heavy documents carry many large terms so
    // that the sum can saturate under the larger settings.
    task automatic send_document(input bit heavy);
        t_term       t;
        int          n;
        logic [31:0] id;
        logic [15:0] len;
        if (heavy)
            n = $urandom_range(22, 26);
        else if ($urandom_range(9) == 0)
            n = $urandom_range(7, 12);
        else
            n = $urandom_range(1, 4);
        id = $urandom;
        case ($urandom_range(5))
            0:       len = 16'd0;
            1:       len = 16'hFFFF;
            2:       len = 16'($urandom);
            default: len = 16'($urandom_range(1, 600));
        endcase
        if (heavy && $urandom_range(1) == 0)
            len = 16'd0;
        for (int k = 0; k < n; k++) begin
            t.doc_id = ($urandom_range(19) == 0) ? 32'($urandom) : id;
            t.doc_length = ($urandom_range(9) == 0) ? 16'($urandom) : len;
            case ($urandom_range(9))
                0:       t.term_freq = 16'd0;
                1:       t.term_freq = 16'($urandom);
                2:       t.term_freq = 16'hFFFF;
                default: t.term_freq = 16'($urandom_range(1, 12));
            endcase
            case ($urandom_range(19))
                0:       t.query_freq = 8'd0;
                1:       t.query_freq = 8'hFF;
                2, 3:    t.query_freq = 8'($urandom);
                default: t.query_freq = 8'($urandom_range(1, 4));
            endcase
            case ($urandom_range(7))
                0:       t.term_weight = 24'($urandom);
                1:       t.term_weight = 24'd0;
                default: t.term_weight = 24'($urandom_range(1 << 14, 1 << 19));
            endcase
            if (heavy) begin
                t.term_freq   = 16'($urandom_range(60000, 65535));
                t.query_freq  = 8'($urandom_range(250, 255));
                t.term_weight = 24'($urandom_range(24'hF0_0000, 24'hFF_FFFF));
            end
            // A stray last bit now and then splits a document early.
            t.last = (k == n - 1) || ($urandom_range(33) == 0);
            send_term(t, 1'b0, '0, 1'b0);
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_doc_score want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_scores.size() == 0) begin
                $error("unexpected result: doc_id_out %0h score %0h overflowed %0b",
                       o_doc_id_out, o_score, o_overflowed);
                mismatches++;
            end else begin
                want = pending_scores.pop_front();
                if (o_doc_id_out !== want.doc_id) begin
                    $error("doc_id_out: expected %0h, actual %0h", want.doc_id, o_doc_id_out);
                    mismatches++;
                end
                if (o_score !== want.score) begin
                    $error("score: expected %0h, actual %0h", want.score, o_score);
                    mismatches++;
                end
                if (o_overflowed !== want.overflowed) begin
                    $error("overflowed: expected %0b, actual %0b",
                           want.overflowed, o_overflowed);
                    mismatches++;
                end
            end
        end
    end

    // Receiver backpressure, with a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        static int hold_seen = 0;
        static int hold_left = 0;
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Ends the run when no transaction of any kind has happened for too long.
    always @(posedge i_clk) begin
        static int quiet_cycles = 0;
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bm25_document_scorer regression: fail");
            $finish;
        end
    end

    initial begin
        int     phase_start;
        bit     paused;
        t_term  t;
        k1_setting        = K1_RESET;
        b_setting         = B_RESET;
        k3_setting        = K3_RESET;
        avg_len_setting   = AVG_RESET;
        running_score     = '0;
        running_saturated = 1'b0;
        send_idle_pct     = 12;
        recv_stall_pct    = 52;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_SCRIPTED; i++) begin
            t = '{SCRIPT[i].doc_id, SCRIPT[i].doc_length, SCRIPT[i].term_freq,
                  SCRIPT[i].query_freq, SCRIPT[i].term_weight, SCRIPT[i].last};
            send_term(t, SCRIPT[i].has_score, SCRIPT[i].score, SCRIPT[i].overflowed);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: program_scorer(24'h00_0000, 24'h00_0000, 24'h00_0000, 24'h00_0000);
                // b above one and every data bit set, upper bits masked off.
                1: program_scorer(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
                2: program_scorer(24'h00_FFFF, 24'(B_ONE), 24'h00_FFFF, 24'd1);
                3: program_scorer(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
                4: program_scorer(24'($urandom_range(4096, 8192)),
                                  24'($urandom_range(16384, 32768)),
                                  24'($urandom_range(0, 2000)),
                                  24'($urandom_range(50 * 256, 500 * 256)));
                default: program_scorer(24'(K1_RESET), 24'(B_RESET), 24'(K3_RESET),
                                        24'(AVG_RESET));
            endcase
            if (phase < 2) begin
                send_idle_pct  = 12;
                recv_stall_pct = 52;
            end else if (phase < 4) begin
                send_idle_pct  = 52;
                recv_stall_pct = 12;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            phase_start = terms_sent;
            paused = 1'b0;
            if (phase == 1) begin
                // Short documents while the receiver holds off fill the
                // output register and back up into the input channel.
                hold_requests++;
                for (int k = 0; k < 12; k++) begin
                    t = '{32'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                          24'($urandom), 1'b1};
                    send_term(t, 1'b0, '0, 1'b0);
                end
            end
            while (terms_sent - phase_start < PHASE_TERMS) begin
                if (phase == 3 && !paused && terms_sent - phase_start > PHASE_TERMS / 2) begin
                    paused = 1'b1;
                    settle();
                end
                send_document($urandom_range(99) < 6);
            end
        end

        settle();
        if (mismatches == 0)
            $display("bm25_document_scorer regression: pass");
        else
            $display("bm25_document_scorer regression: fail");
        $finish;
    end

endmodule

[files.f]
sv/bm25s_pkg.sv
sv/bm25s_div.sv
sv/bm25s_core.sv
sv/bm25_document_scorer.sv
sv/bm25s_checker.sv
bench/bm25_document_scorer_test.sv
